FILE: src/edcu_pkg.sv
// ---------------------------------------------------------------------------
// edcu_pkg
// shared types, codes and calendar helpers for the epoch day calendar unit
// ---------------------------------------------------------------------------
package edcu_pkg;

   localparam logic [11:0] EPOCH_YEAR = 12'd1970;
   localparam logic [3:0]  LAST_MONTH = 4'd12;

   typedef enum logic [1:0] {
      KIND_SET_DATE   = 2'd0,
      KIND_ADD_DAYS   = 2'd1,
      KIND_ADD_MONTHS = 2'd2,
      KIND_ADD_YEARS  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SET_YEAR,
      ST_SET_MONTH,
      ST_PRE_YEAR,
      ST_PRE_MONTH,
      ST_ADD,
      ST_DEC_INIT,
      ST_POST_YEAR,
      ST_POST_MONTH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_FAIL,
      OP_PRE_INIT,
      OP_SET_YEAR,
      OP_SET_MONTH,
      OP_COMMIT_SET,
      OP_COMMIT_DAYS,
      OP_DEC_YEAR,
      OP_DEC_MONTH,
      OP_ADD_STEP,
      OP_COMMIT_ADD,
      OP_DEC_INIT,
      OP_OUT_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     set_valid;
      logic     amt_neg;
      logic     sety_done;
      logic     setm_done;
      logic     decy_done;
      logic     decm_done;
      logic     add_done;
      logic     out_free;
   } stat_type;

   function automatic logic is_leap(input logic [11:0] year);
      return (year[1:0] == 2'b00);
   endfunction

   function automatic logic [8:0] year_len(input logic leap);
      return leap ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // day count of 31 dec of the last year, evaluated at elaboration
   function automatic int unsigned max_count(input int unsigned last_year);
      int unsigned total;
      total = 0;
      for (int unsigned y = int'(EPOCH_YEAR); y <= last_year; y++) begin
         total += ((y % 4) == 0) ? 366 : 365;
      end
      return total;
   endfunction

endpackage

FILE: src/edcu_req_if.sv
// ---------------------------------------------------------------------------
// edcu_req_if
// request channel: valid/ready handshake with one operation per transfer
// ---------------------------------------------------------------------------
interface edcu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [4:0]         set_day;
   logic [3:0]         set_month;
   logic [11:0]        set_year;
   logic signed [16:0] amount;

   modport source (output valid, kind, set_day, set_month, set_year, amount, input ready);
   modport sink   (input valid, kind, set_day, set_month, set_year, amount, output ready);
endinterface

FILE: src/edcu_rsp_if.sv
// ---------------------------------------------------------------------------
// edcu_rsp_if
// response channel: valid/ready handshake with one result per transfer
// ---------------------------------------------------------------------------
interface edcu_rsp_if;
   logic        valid;
   logic        ready;
   logic        error;
   logic [15:0] day_count;
   logic [4:0]  day_of_month;
   logic [3:0]  month_number;
   logic [11:0] year_number;

   modport source (output valid, error, day_count, day_of_month, month_number, year_number,
                   input ready);
   modport sink   (input valid, error, day_count, day_of_month, month_number, year_number,
                   output ready);
endinterface

FILE: src/edcu_ctrl.sv
// ---------------------------------------------------------------------------
// edcu_ctrl
// sequencer that steps the datapath through one operation at a time
// ---------------------------------------------------------------------------
module edcu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  edcu_pkg::stat_type stat,
   output edcu_pkg::cmd_type  cmd
);

   edcu_pkg::state_type state_ff;
   edcu_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edcu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = edcu_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         edcu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = edcu_pkg::OP_LOAD;
               state_in = edcu_pkg::ST_DISPATCH;
            end
         end
         edcu_pkg::ST_DISPATCH: begin
            case (stat.kind)
               edcu_pkg::KIND_SET_DATE: begin
                  if (stat.set_valid) begin
                     state_in = edcu_pkg::ST_SET_YEAR;
                  end else begin
                     cmd.op   = edcu_pkg::OP_FAIL;
                     state_in = edcu_pkg::ST_DEC_INIT;
                  end
               end
               edcu_pkg::KIND_ADD_DAYS: begin
                  cmd.op   = edcu_pkg::OP_COMMIT_DAYS;
                  state_in = edcu_pkg::ST_DEC_INIT;
               end
               default: begin
                  if (stat.amt_neg) begin
                     cmd.op   = edcu_pkg::OP_FAIL;
                     state_in = edcu_pkg::ST_DEC_INIT;
                  end else begin
                     cmd.op   = edcu_pkg::OP_PRE_INIT;
                     state_in = edcu_pkg::ST_PRE_YEAR;
                  end
               end
            endcase
         end
         edcu_pkg::ST_SET_YEAR: begin
            if (stat.sety_done) begin
               state_in = edcu_pkg::ST_SET_MONTH;
            end else begin
               cmd.op = edcu_pkg::OP_SET_YEAR;
            end
         end
         edcu_pkg::ST_SET_MONTH: begin
            if (stat.setm_done) begin
               cmd.op   = edcu_pkg::OP_COMMIT_SET;
               state_in = edcu_pkg::ST_DEC_INIT;
            end else begin
               cmd.op = edcu_pkg::OP_SET_MONTH;
            end
         end
         edcu_pkg::ST_PRE_YEAR: begin
            if (stat.decy_done) begin
               state_in = edcu_pkg::ST_PRE_MONTH;
            end else begin
               cmd.op = edcu_pkg::OP_DEC_YEAR;
            end
         end
         edcu_pkg::ST_PRE_MONTH: begin
            if (stat.decm_done) begin
               state_in = edcu_pkg::ST_ADD;
            end else begin
               cmd.op = edcu_pkg::OP_DEC_MONTH;
            end
         end
         edcu_pkg::ST_ADD: begin
            if (stat.add_done) begin
               cmd.op   = edcu_pkg::OP_COMMIT_ADD;
               state_in = edcu_pkg::ST_DEC_INIT;
            end else begin
               cmd.op = edcu_pkg::OP_ADD_STEP;
            end
         end
         edcu_pkg::ST_DEC_INIT: begin
            cmd.op   = edcu_pkg::OP_DEC_INIT;
            state_in = edcu_pkg::ST_POST_YEAR;
         end
         edcu_pkg::ST_POST_YEAR: begin
            if (stat.decy_done) begin
               state_in = edcu_pkg::ST_POST_MONTH;
            end else begin
               cmd.op = edcu_pkg::OP_DEC_YEAR;
            end
         end
         edcu_pkg::ST_POST_MONTH: begin
            if (!stat.decm_done) begin
               cmd.op = edcu_pkg::OP_DEC_MONTH;
            end else if (stat.out_free) begin
               cmd.op   = edcu_pkg::OP_OUT_LOAD;
               state_in = edcu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = edcu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/edcu_dp.sv
// ---------------------------------------------------------------------------
// edcu_dp
// datapath: day count register, iteration registers and result register
// ---------------------------------------------------------------------------
module edcu_dp #(
   parameter int unsigned LAST_YEAR = 2099
) (
   input  logic               clock,
   input  logic               reset,
   input  edcu_pkg::cmd_type  cmd,
   output edcu_pkg::stat_type stat,
   input  logic [1:0]         req_kind,
   input  logic [4:0]         req_set_day,
   input  logic [3:0]         req_set_month,
   input  logic [11:0]        req_set_year,
   input  logic signed [16:0] req_amount,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_error,
   output logic [15:0]        rsp_day_count,
   output logic [4:0]         rsp_day_of_month,
   output logic [3:0]         rsp_month_number,
   output logic [11:0]        rsp_year_number
);

   localparam logic [16:0] MAX_COUNT = 17'(edcu_pkg::max_count(LAST_YEAR));
   localparam logic [11:0] LAST_YR   = 12'(LAST_YEAR);

   // latched request
   edcu_pkg::kind_type kind_ff, kind_in;
   logic [4:0]         sd_ff, sd_in;
   logic [3:0]         sm_ff, sm_in;
   logic [11:0]        sy_ff, sy_in;
   logic signed [16:0] amt_ff, amt_in;

   // working state
   logic        err_ff, err_in;
   logic [15:0] epoch_ff, epoch_in;
   logic [16:0] acc_ff, acc_in;
   logic [11:0] yr_ff, yr_in;
   logic [3:0]  mon_ff, mon_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] cnt_ff, cnt_in;

   // result register
   logic        rv_ff, rv_in;
   logic        rerr_ff, rerr_in;
   logic [15:0] rcount_ff, rcount_in;
   logic [4:0]  rday_ff, rday_in;
   logic [3:0]  rmon_ff, rmon_in;
   logic [11:0] ryear_ff, ryear_in;

   logic               cur_leap;
   logic [8:0]         cur_ylen;
   logic [4:0]         cur_mlen;
   logic [11:0]        yr_inc;
   logic [8:0]         inc_ylen;
   logic [4:0]         set_mlen;
   logic [16:0]        set_sum;
   logic signed [17:0] day_sum;

   assign cur_leap = edcu_pkg::is_leap(yr_ff);
   assign cur_ylen = edcu_pkg::year_len(cur_leap);
   assign cur_mlen = edcu_pkg::month_len(mon_ff, cur_leap);
   assign yr_inc   = yr_ff + 12'd1;
   assign inc_ylen = edcu_pkg::year_len(edcu_pkg::is_leap(yr_inc));
   assign set_mlen = edcu_pkg::month_len(sm_ff, edcu_pkg::is_leap(sy_ff));
   assign set_sum  = acc_ff + {12'd0, sd_ff};
   assign day_sum  = $signed({2'b00, epoch_ff}) + 18'(amt_ff);

   always_comb begin
      stat.kind      = kind_ff;
      stat.set_valid = (sy_ff >= edcu_pkg::EPOCH_YEAR) && (sy_ff <= LAST_YR) &&
                       (sd_ff != 5'd0) && (sd_ff <= set_mlen);
      stat.amt_neg   = amt_ff[16];
      stat.sety_done = (yr_ff == sy_ff);
      stat.setm_done = (mon_ff == sm_ff);
      stat.decy_done = (rem_ff <= {7'd0, cur_ylen});
      stat.decm_done = (mon_ff == edcu_pkg::LAST_MONTH) || (rem_ff <= {11'd0, cur_mlen});
      stat.add_done  = (cnt_ff == 16'd0) || (acc_ff > MAX_COUNT);
      stat.out_free  = !rv_ff || rsp_ready;
   end

   always_comb begin
      kind_in   = kind_ff;
      sd_in     = sd_ff;
      sm_in     = sm_ff;
      sy_in     = sy_ff;
      amt_in    = amt_ff;
      err_in    = err_ff;
      epoch_in  = epoch_ff;
      acc_in    = acc_ff;
      yr_in     = yr_ff;
      mon_in    = mon_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      rv_in     = rv_ff && !rsp_ready;
      rerr_in   = rerr_ff;
      rcount_in = rcount_ff;
      rday_in   = rday_ff;
      rmon_in   = rmon_ff;
      ryear_in  = ryear_ff;
      case (cmd.op)
         edcu_pkg::OP_LOAD: begin
            kind_in = edcu_pkg::kind_type'(req_kind);
            sd_in   = req_set_day;
            sm_in   = req_set_month;
            sy_in   = req_set_year;
            amt_in  = req_amount;
            err_in  = 1'b0;
            acc_in  = 17'd0;
            yr_in   = edcu_pkg::EPOCH_YEAR;
            mon_in  = 4'd1;
         end
         edcu_pkg::OP_FAIL: begin
            err_in = 1'b1;
         end
         edcu_pkg::OP_PRE_INIT: begin
            rem_in = epoch_ff;
            yr_in  = edcu_pkg::EPOCH_YEAR;
            mon_in = 4'd1;
            acc_in = {1'b0, epoch_ff};
            cnt_in = amt_ff[15:0];
         end
         edcu_pkg::OP_SET_YEAR: begin
            acc_in = acc_ff + {8'd0, cur_ylen};
            yr_in  = yr_inc;
         end
         edcu_pkg::OP_SET_MONTH: begin
            acc_in = acc_ff + {12'd0, edcu_pkg::month_len(mon_ff, edcu_pkg::is_leap(sy_ff))};
            mon_in = mon_ff + 4'd1;
         end
         edcu_pkg::OP_COMMIT_SET: begin
            if (set_sum > MAX_COUNT) begin
               err_in = 1'b1;
            end else begin
               epoch_in = set_sum[15:0];
            end
         end
         edcu_pkg::OP_COMMIT_DAYS: begin
            if (day_sum < 18'sd1 || day_sum > $signed({1'b0, MAX_COUNT})) begin
               err_in = 1'b1;
            end else begin
               epoch_in = day_sum[15:0];
            end
         end
         edcu_pkg::OP_DEC_YEAR: begin
            rem_in = rem_ff - {7'd0, cur_ylen};
            yr_in  = yr_inc;
         end
         edcu_pkg::OP_DEC_MONTH: begin
            rem_in = rem_ff - {11'd0, cur_mlen};
            mon_in = mon_ff + 4'd1;
         end
         edcu_pkg::OP_ADD_STEP: begin
            cnt_in = cnt_ff - 16'd1;
            if (kind_ff == edcu_pkg::KIND_ADD_MONTHS) begin
               acc_in = acc_ff + {12'd0, cur_mlen};
               if (mon_ff == edcu_pkg::LAST_MONTH) begin
                  mon_in = 4'd1;
                  yr_in  = yr_inc;
               end else begin
                  mon_in = mon_ff + 4'd1;
               end
            end else begin
               // the year moved into decides the length added
               yr_in  = yr_inc;
               acc_in = acc_ff + {8'd0, inc_ylen};
            end
         end
         edcu_pkg::OP_COMMIT_ADD: begin
            if (acc_ff > MAX_COUNT) begin
               err_in = 1'b1;
            end else begin
               epoch_in = acc_ff[15:0];
            end
         end
         edcu_pkg::OP_DEC_INIT: begin
            rem_in = epoch_ff;
            yr_in  = edcu_pkg::EPOCH_YEAR;
            mon_in = 4'd1;
         end
         edcu_pkg::OP_OUT_LOAD: begin
            rv_in     = 1'b1;
            rerr_in   = err_ff;
            rcount_in = epoch_ff;
            rday_in   = rem_ff[4:0];
            rmon_in   = mon_ff;
            ryear_in  = yr_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= 16'd1;
         rv_ff    <= 1'b0;
      end else begin
         epoch_ff <= epoch_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      sd_ff     <= sd_in;
      sm_ff     <= sm_in;
      sy_ff     <= sy_in;
      amt_ff    <= amt_in;
      err_ff    <= err_in;
      acc_ff    <= acc_in;
      yr_ff     <= yr_in;
      mon_ff    <= mon_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      rerr_ff   <= rerr_in;
      rcount_ff <= rcount_in;
      rday_ff   <= rday_in;
      rmon_ff   <= rmon_in;
      ryear_ff  <= ryear_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_error        = rerr_ff;
   assign rsp_day_count    = rcount_ff;
   assign rsp_day_of_month = rday_ff;
   assign rsp_month_number = rmon_ff;
   assign rsp_year_number  = ryear_ff;

   // stored count never leaves the calendar range
   a_epoch_range: assert property (@(posedge clock) disable iff (reset)
      (epoch_ff >= 16'd1) && ({1'b0, epoch_ff} <= MAX_COUNT))
      else $error("day count out of range");

   // a result is never written over one still waiting
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == edcu_pkg::OP_OUT_LOAD) |-> (!rv_ff || rsp_ready))
      else $error("result register overwritten");

   // an overflowing month or year add keeps the count
   a_add_keep: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == edcu_pkg::OP_COMMIT_ADD && acc_ff > MAX_COUNT) |=> $stable(epoch_ff))
      else $error("count changed on refused add");

   // a refused operation reports an error in its result
   a_fail_err: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == edcu_pkg::OP_FAIL) |=> err_ff)
      else $error("refused operation lost its error flag");

endmodule

FILE: src/epoch_day_calendar_unit.sv
// ---------------------------------------------------------------------------
// epoch_day_calendar_unit
// calendar date kept as a day count since 1 jan 1970 (day 1)
// ---------------------------------------------------------------------------
// Holds one date as a day count, day 1 being 1 Jan 1970, and on each request
// sets it from day/month/year, adds signed days, adds months or adds years,
// then returns the count with its day, month and year. One request is worked
// at a time by a sequencer that steps the datapath once per cycle, one year
// or one month per step. Every request ends by stepping off the years and
// then the months of the new count to decompose it. Before that, a set
// date steps one year for each year after 1970 and one month for each
// month before the set month, and an add of months or years decomposes
// the current count, then steps one added month or year at a time
// (stopping as soon as the range is passed, at most 1560 months or 130
// years). After each result the sequencer returns to idle, where it takes
// the next request. A new request is taken while the previous result
// still waits in the output register; that request then stalls at its
// end until the waiting result has been taken.
// ---------------------------------------------------------------------------
module epoch_day_calendar_unit #(
   parameter int unsigned LAST_YEAR = 2099  // last calendar year, 1971 to 2099
) (
   input logic          clock,
   input logic          reset,
   edcu_req_if.sink     req_ch,
   edcu_rsp_if.source   rsp_ch
);

   // command and status between sequencer and datapath
   edcu_pkg::cmd_type  cmd;
   edcu_pkg::stat_type stat;

   // sequencer: one state per loop of the operation
   edcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: count register, loop counters and result register
   edcu_dp #(
      .LAST_YEAR (LAST_YEAR)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_ch.kind),
      .req_set_day      (req_ch.set_day),
      .req_set_month    (req_ch.set_month),
      .req_set_year     (req_ch.set_year),
      .req_amount       (req_ch.amount),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_error        (rsp_ch.error),
      .rsp_day_count    (rsp_ch.day_count),
      .rsp_day_of_month (rsp_ch.day_of_month),
      .rsp_month_number (rsp_ch.month_number),
      .rsp_year_number  (rsp_ch.year_number)
   );

endmodule

FILE: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the epoch day calendar unit
// ---------------------------------------------------------------------------
// A directed run covers the range ends, invalid dates, barred negative
// amounts and the month wrap. A long random run follows, made mostly of
// well-formed operations. A local calendar predictor tracks the day count and
// works out each result when the request transfer happens. The response side
// compares every field in order. Both sides insert random gaps and stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned FIRST_YEAR   = 1970;
   localparam int unsigned FINAL_YEAR   = 2099;
   localparam int unsigned RANDOM_OPS   = 1200;
   localparam int unsigned DRAIN_CYCLES = 2000;

   typedef struct {
      edcu_pkg::kind_type kind;
      logic [4:0]         set_day;
      logic [3:0]         set_month;
      logic [11:0]        set_year;
      logic signed [16:0] amount;
   } date_op_type;

   typedef struct {
      logic        error;
      logic [15:0] day_count;
      logic [4:0]  day_of_month;
      logic [3:0]  month_number;
      logic [11:0] year_number;
   } date_rsp_type;

   logic clock = 1'b0;
   logic reset;

   edcu_req_if req_ch();
   edcu_rsp_if rsp_ch();

   epoch_day_calendar_unit #(.LAST_YEAR(FINAL_YEAR)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // pending operations, filled up front and drained by the driver
   date_op_type    pending_ops[$];
   // predicted results waiting for their response transfer
   date_rsp_type   date_expect_q[$];

   // predictor copy of the stored date
   int unsigned epoch_count = 1;

   int unsigned fail_count    = 0;
   int unsigned checked_count = 0;
   int unsigned refused_count = 0;
   int unsigned kind_count[4] = '{default: 0};

   // free-running cycle count, used to open stretches without any idling
   int unsigned tick = 0;
   logic        calm;

   assign calm = (tick % 5000) < 1000;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      tick <= tick + 1;
   end

   // ------------------------------------------------------------------------
   // calendar predictor
   // ------------------------------------------------------------------------

   // leap rule divisible by 4 is exact over the supported years
   function automatic int unsigned days_in_year(input int unsigned y);
      return (y % 4 == 0) ? 366 : 365;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return (y % 4 == 0) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // count of 31 dec of the final year, the highest count the unit may hold
   function automatic int unsigned top_count();
      int unsigned total;
      total = 0;
      for (int unsigned y = FIRST_YEAR; y <= FINAL_YEAR; y++) begin
         total += days_in_year(y);
      end
      return total;
   endfunction

   // break a day count into day, month and year
   function automatic void split_count(input int unsigned count, output int unsigned dd,
                                       output int unsigned mm, output int unsigned yy);
      int unsigned d;
      int unsigned m;
      int unsigned y;
      d = count;
      m = 1;
      y = FIRST_YEAR;
      while (d > days_in_year(y) && y < 4095) begin
         d -= days_in_year(y);
         y++;
      end
      while (m < 12 && d > days_in_month(m, y)) begin
         d -= days_in_month(m, y);
         m++;
      end
      dd = d;
      mm = m;
      yy = y;
   endfunction

   // apply one operation to the predicted date and return the result it gives
   function automatic date_rsp_type apply_date_op(input date_op_type op);
      date_rsp_type r;
      int unsigned  limit;
      int unsigned  c;
      int unsigned  n;
      int unsigned  d;
      int unsigned  m;
      int unsigned  y;
      int           nxt;
      logic         bad;
      limit = top_count();
      bad   = 1'b0;
      nxt   = int'(epoch_count);
      case (op.kind)
         edcu_pkg::KIND_SET_DATE: begin
            if (op.set_year < FIRST_YEAR || op.set_year > FINAL_YEAR || op.set_day == 0 ||
                op.set_day > days_in_month(op.set_month, op.set_year)) begin
               bad = 1'b1;
            end else begin
               c = 0;
               for (int unsigned i = FIRST_YEAR; i < op.set_year; i++) c += days_in_year(i);
               for (int unsigned i = 1; i < op.set_month; i++)
                  c += days_in_month(i, op.set_year);
               nxt = int'(c + op.set_day);
            end
         end
         edcu_pkg::KIND_ADD_DAYS: begin
            nxt = int'(epoch_count) + int'(op.amount);
         end
         default: begin
            if (op.amount < 0) begin
               bad = 1'b1;
            end else begin
               n = op.amount;
               c = epoch_count;
               split_count(epoch_count, d, m, y);
               // month steps take the length of the month being left,
               // year steps the length of the year being entered
               for (int unsigned i = 0; i < n && c <= limit; i++) begin
                  if (op.kind == edcu_pkg::KIND_ADD_MONTHS) begin
                     c += days_in_month(m, y);
                     m++;
                     if (m == 13) begin
                        m = 1;
                        y++;
                     end
                  end else begin
                     y++;
                     c += days_in_year(y);
                  end
               end
               nxt = (c > limit) ? int'(limit + 1) : int'(c);
            end
         end
      endcase
      if (!bad && (nxt < 1 || nxt > int'(limit))) bad = 1'b1;
      if (!bad) epoch_count = nxt;
      split_count(epoch_count, d, m, y);
      r.error        = bad;
      r.day_count    = epoch_count[15:0];
      r.day_of_month = d[4:0];
      r.month_number = m[3:0];
      r.year_number  = y[11:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // random shaping
   // ------------------------------------------------------------------------

   // idle length for either side: mostly short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm)   return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 24);
      return $urandom_range(40, 300);
   endfunction

   task automatic queue_op(input edcu_pkg::kind_type k, input int d, input int m,
                           input int y, input int a);
      date_op_type op;
      op.kind      = k;
      op.set_day   = d[4:0];
      op.set_month = m[3:0];
      op.set_year  = y[11:0];
      op.amount    = a[16:0];
      pending_ops.push_back(op);
   endtask

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   date_op_type req_item;
   logic        req_live;
   int unsigned req_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_live = 1'b0;
         req_gap  = 0;
      end else begin
         // transfer of the item on the bus: predict its result now
         if (req_live && req_ch.ready) begin
            date_expect_q.push_back(apply_date_op(req_item));
            kind_count[req_item.kind]++;
            if (date_expect_q[$].error) refused_count++;
            req_live = 1'b0;
            req_gap  = pick_gap();
         end
         if (!req_live) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_ops.size() > 0) begin
               req_item = pending_ops.pop_front();
               req_ch.kind      <= req_item.kind;
               req_ch.set_day   <= req_item.set_day;
               req_ch.set_month <= req_item.set_month;
               req_ch.set_year  <= req_item.set_year;
               req_ch.amount    <= req_item.amount;
               req_live = 1'b1;
            end
         end
         req_ch.valid <= req_live;
      end
   end

   // ------------------------------------------------------------------------
   // response monitor and checker
   // ------------------------------------------------------------------------
   int unsigned rsp_hold;

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      date_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (date_expect_q.size() == 0) begin
               $error("result transfer with no prediction waiting: count %0d",
                      rsp_ch.day_count);
               fail_count++;
            end else begin
               want = date_expect_q.pop_front();
               checked_count++;
               check_field("error",        want.error,        rsp_ch.error);
               check_field("day_count",    want.day_count,    rsp_ch.day_count);
               check_field("day_of_month", want.day_of_month, rsp_ch.day_of_month);
               check_field("month_number", want.month_number, rsp_ch.month_number);
               check_field("year_number",  want.year_number,  rsp_ch.year_number);
            end
         end
         // backpressure: hold ready low for a random stretch now and then
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) rsp_hold = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int                 k;
      int                 sel;
      int                 d;
      int                 m;
      int                 y;
      int                 a;
      edcu_pkg::kind_type kd;

      reset = 1'b1;

      // directed: range ends, invalid dates, barred negatives, month wrap
      queue_op(edcu_pkg::KIND_SET_DATE,    1,  1, 1970,      0);   // first day
      queue_op(edcu_pkg::KIND_ADD_DAYS,    0,  0,    0,     -1);   // below day 1
      queue_op(edcu_pkg::KIND_ADD_DAYS,    0,  0,    0,      0);
      queue_op(edcu_pkg::KIND_SET_DATE,   31, 12, 2099,      0);   // last day
      queue_op(edcu_pkg::KIND_ADD_DAYS,    0,  0,    0,      1);   // past the end
      queue_op(edcu_pkg::KIND_ADD_YEARS,   0,  0,    0,      1);
      queue_op(edcu_pkg::KIND_ADD_MONTHS,  0,  0,    0,      1);
      queue_op(edcu_pkg::KIND_SET_DATE,   29,  2, 2096,      0);   // leap day
      queue_op(edcu_pkg::KIND_ADD_YEARS,   0,  0,    0,      1);   // into a common year
      queue_op(edcu_pkg::KIND_SET_DATE,   29,  2, 2099,      0);   // not a leap year
      queue_op(edcu_pkg::KIND_SET_DATE,    0,  5, 2000,      0);   // day zero
      queue_op(edcu_pkg::KIND_SET_DATE,   31,  4, 2000,      0);   // day past month end
      queue_op(edcu_pkg::KIND_SET_DATE,    1,  0, 2000,      0);   // month zero
      queue_op(edcu_pkg::KIND_SET_DATE,   31, 15, 4095,      0);   // all fields at max bits
      queue_op(edcu_pkg::KIND_SET_DATE,    1,  1, 1969,      0);   // year before epoch
      queue_op(edcu_pkg::KIND_SET_DATE,    1,  1, 2100,      0);   // year after the last
      queue_op(edcu_pkg::KIND_SET_DATE,   31,  1, 2000,      0);
      queue_op(edcu_pkg::KIND_ADD_MONTHS,  0,  0,    0,      1);   // day not clamped
      queue_op(edcu_pkg::KIND_SET_DATE,   15, 12, 2000,      0);
      queue_op(edcu_pkg::KIND_ADD_MONTHS,  0,  0,    0,      1);   // december wrap
      queue_op(edcu_pkg::KIND_ADD_MONTHS,  0,  0,    0,     -1);   // negative months
      queue_op(edcu_pkg::KIND_ADD_YEARS,   0,  0,    0, -65536);   // negative years, min
      queue_op(edcu_pkg::KIND_ADD_DAYS,    0,  0,    0,  65535);   // max raw amount
      queue_op(edcu_pkg::KIND_ADD_DAYS,    0,  0,    0, -47482);
      queue_op(edcu_pkg::KIND_ADD_YEARS,   0,  0,    0,      0);
      queue_op(edcu_pkg::KIND_SET_DATE,    1,  1, 1970,      0);
      queue_op(edcu_pkg::KIND_ADD_MONTHS,  0,  0,    0,   1600);   // runs off the range

      // random: mostly well-formed operations, some raw noise
      for (int i = 0; i < RANDOM_OPS; i++) begin
         k   = $urandom_range(0, 99);
         sel = $urandom_range(0, 99);
         d   = $urandom;
         m   = $urandom;
         y   = $urandom;
         a   = $urandom;
         if (k < 30) begin
            kd = edcu_pkg::KIND_SET_DATE;
            if (sel < 80) begin
               // valid date, with extra weight near both range ends
               if (sel < 10)      y = $urandom_range(2090, 2099);
               else if (sel < 16) y = $urandom_range(1970, 1973);
               else               y = $urandom_range(1970, 2099);
               m = $urandom_range(1, 12);
               d = $urandom_range(1, days_in_month(m, y));
            end else if (sel < 90) begin
               y = $urandom_range(1965, 2104);
               m = $urandom_range(0, 15);
               d = $urandom_range(0, 31);
            end
         end else if (k < 55) begin
            kd = edcu_pkg::KIND_ADD_DAYS;
            if (sel < 50)      a = int'($urandom_range(0, 1600)) - 800;
            else if (sel < 80) a = int'($urandom_range(0, 94964)) - 47482;
            else if (sel < 90) a = int'($urandom_range(0, 80)) - 40;
         end else if (k < 80) begin
            kd = edcu_pkg::KIND_ADD_MONTHS;
            if (sel < 85)      a = $urandom_range(0, 24);
            else if (sel < 93) a = $urandom_range(25, 200);
            else if (sel < 96) a = $urandom_range(1000, 2000);
            else if (sel < 98) a = -int'($urandom_range(1, 65536));
         end else begin
            kd = edcu_pkg::KIND_ADD_YEARS;
            if (sel < 85)      a = $urandom_range(0, 10);
            else if (sel < 93) a = $urandom_range(11, 140);
            else if (sel < 97) a = -int'($urandom_range(1, 65536));
         end
         queue_op(kd, d, m, y, a);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all operations out, then every prediction met
      while (pending_ops.size() > 0 || req_live) @(posedge clock);
      while (date_expect_q.size() > 0) @(posedge clock);
      // watch for stray results after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("operations: %0d set date, %0d add days, %0d add months, %0d add years",
               kind_count[edcu_pkg::KIND_SET_DATE], kind_count[edcu_pkg::KIND_ADD_DAYS],
               kind_count[edcu_pkg::KIND_ADD_MONTHS], kind_count[edcu_pkg::KIND_ADD_YEARS]);
      $display("results checked: %0d, refused with error: %0d, field failures: %0d",
               checked_count, refused_count, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #100_000_000;
      $display("timeout with %0d results outstanding", date_expect_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
